// ===== rtl/core/lac_pkg.sv =====
// ----------------------------------------------------------------------------
// lac_pkg
// Shared widths, constants, codes and controller/datapath types for the
// load and angle conditioner.
// ----------------------------------------------------------------------------
package lac_pkg;

    // field widths
    localparam int SAMPLE_W     = 24;
    localparam int ANGLE_COUNTS = 4096;
    localparam int ANGLE_W      = $clog2(ANGLE_COUNTS);
    localparam int ANGLE_OUT_W  = ANGLE_W + 1;
    localparam int ANGLE_DIFF_W = ANGLE_W + 2;
    localparam int FRAC_W       = 16;
    localparam int SUM_W        = 32;
    // a tare shortened mid-tare can exceed the sample range
    localparam int TARE_W       = SUM_W;
    localparam int FILT_W       = TARE_W + FRAC_W;
    localparam int DIFF_W       = FILT_W + 1;
    localparam int FORCE_W      = 48;
    localparam int ALPHA_W      = 16;
    localparam int SCALE_W      = 32;
    localparam int TARE_N_W     = 8;
    localparam int PROD_W       = DIFF_W + SCALE_W;
    localparam int MAG_W        = PROD_W - FRAC_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCALE        = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_SAMPLES       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_NEGATIVE = CFG_IDX_W'(3);

    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = ALPHA_W'(9830);
    localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(65536);
    localparam logic [TARE_N_W-1:0] TARE_N_RST = TARE_N_W'(20);

    // sequencer step counts
    localparam int DIV_STEPS   = SUM_W;
    localparam int FILT_STEPS  = ALPHA_W;
    localparam int FORCE_STEPS = SCALE_W;
    localparam int STEP_W      = $clog2(SUM_W);

    // saturation limits of the force result
    localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV,
        ST_TARE_SET,
        ST_FILT_INIT,
        ST_FILT_MUL,
        ST_FILT_UPD,
        ST_FORCE_INIT,
        ST_FORCE_MUL,
        ST_DONE
    } state_t;

    // conditioning phase
    typedef enum logic [1:0] {
        PH_DISCARD,
        PH_TARE,
        PH_RUN
    } phase_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic tare_acc;
        logic div_init;
        logic div_step;
        logic tare_set;
        logic filt_init;
        logic mul_step;
        logic filt_upd;
        logic force_init;
        logic out_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic tare_last;
    } dp_status_t;

endpackage

// ===== rtl/core/lac_in_if.sv =====
// ----------------------------------------------------------------------------
// lac_in_if
// Sample request channel: one load sample and one angle reading.
// ----------------------------------------------------------------------------
interface lac_in_if;

    logic                               valid;
    logic                               ready;
    logic signed [lac_pkg::SAMPLE_W-1:0] load_raw;
    logic [lac_pkg::ANGLE_W-1:0]        angle_raw;
    logic                               angle_ok;

    modport source (output valid, output load_raw, output angle_raw, output angle_ok,
                    input ready);
    modport sink (input valid, input load_raw, input angle_raw, input angle_ok,
                  output ready);

endinterface

// ===== rtl/core/lac_out_if.sv =====
// ----------------------------------------------------------------------------
// lac_out_if
// Result request channel: scaled force and tared angle.
// ----------------------------------------------------------------------------
interface lac_out_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [lac_pkg::FORCE_W-1:0]     force_value;
    logic signed [lac_pkg::ANGLE_OUT_W-1:0] angle_counts;
    logic                                   angle_valid;

    modport source (output valid, output force_value, output angle_counts,
                    output angle_valid, input ready);
    modport sink (input valid, input force_value, input angle_counts,
                  input angle_valid, output ready);

endinterface

// ===== rtl/core/lac_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lac_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lac_cfg_if;

    logic                             valid;
    logic                             ready;
    logic [lac_pkg::CFG_IDX_W-1:0]    index;
    logic [lac_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

// ===== rtl/core/load_and_angle_conditioner_core.sv =====
// ----------------------------------------------------------------------------
// load_and_angle_conditioner_core
// Tares a load cell stream, low-pass filters it, scales it to force, and
// reports the tared, wrapped angle alongside each filtered sample.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-----------------------------------
//   sample   | in  | valid / ready     | load_raw, angle_raw, angle_ok
//   result   | out | valid / ready     | force_value, angle_counts,
//            |     |                   | angle_valid
//   cfg      | in  | valid / ready = 1 | index, data
//
// The first request after reset is dropped; tare requests are only summed,
// and the last tare request also runs the 32-step serial divider.
// Run requests take 16 shift-add steps for the filter and 32 for the
// force product on one shared multiplier.
// A finished result waits in the output register; the next sample is taken
// meanwhile and stalls only at its own result load.
// Reset clears sequencer, tare and filter state; restores configuration defaults.
// ----------------------------------------------------------------------------
module load_and_angle_conditioner_core (
    input logic   clk,
    input logic   rst_n,
    lac_in_if.sink    sample,
    lac_out_if.source result,
    lac_cfg_if.sink   cfg
);

    lac_pkg::dp_cmd_t    cmd;
    lac_pkg::dp_status_t status;
    logic                cfg_we;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // sequencer
    lac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and state
    lac_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .load_raw     (sample.load_raw),
        .angle_raw    (sample.angle_raw),
        .angle_ok     (sample.angle_ok),
        .force_value  (result.force_value),
        .angle_counts (result.angle_counts),
        .angle_valid  (result.angle_valid)
    );

endmodule

// ===== rtl/core/lac_ctrl.sv =====
// ----------------------------------------------------------------------------
// lac_ctrl
// Sequencer for the conditioner: tracks the discard/tare/run phase and steps
// the datapath through division, filter multiply and force multiply.
// ----------------------------------------------------------------------------
module lac_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  lac_pkg::dp_status_t status,
    output lac_pkg::dp_cmd_t    cmd
);

    lac_pkg::state_t              state_reg;
    lac_pkg::state_t              state_next;
    lac_pkg::phase_t              phase_reg;
    lac_pkg::phase_t              phase_next;
    logic [lac_pkg::STEP_W-1:0]   step_reg;
    logic [lac_pkg::STEP_W-1:0]   step_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         accept;
    logic                         out_free;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // state, phase and step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lac_pkg::ST_IDLE;
            phase_reg     <= lac_pkg::PH_DISCARD;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and phase
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            lac_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        lac_pkg::PH_DISCARD:
                        begin
                            phase_next = lac_pkg::PH_TARE;
                        end
                        lac_pkg::PH_TARE:
                        begin
                            if (status.tare_last)
                            begin
                                state_next = lac_pkg::ST_DIV_INIT;
                            end
                        end
                        default:
                        begin
                            state_next = lac_pkg::ST_FILT_INIT;
                        end
                    endcase
                end
            end
            lac_pkg::ST_DIV_INIT:
            begin
                state_next = lac_pkg::ST_DIV;
            end
            lac_pkg::ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = lac_pkg::ST_TARE_SET;
                end
            end
            lac_pkg::ST_TARE_SET:
            begin
                state_next = lac_pkg::ST_IDLE;
                phase_next = lac_pkg::PH_RUN;
            end
            lac_pkg::ST_FILT_INIT:
            begin
                state_next = lac_pkg::ST_FILT_MUL;
            end
            lac_pkg::ST_FILT_MUL:
            begin
                if (step_reg == '0)
                begin
                    state_next = lac_pkg::ST_FILT_UPD;
                end
            end
            lac_pkg::ST_FILT_UPD:
            begin
                state_next = lac_pkg::ST_FORCE_INIT;
            end
            lac_pkg::ST_FORCE_INIT:
            begin
                state_next = lac_pkg::ST_FORCE_MUL;
            end
            lac_pkg::ST_FORCE_MUL:
            begin
                if (step_reg == '0)
                begin
                    state_next = lac_pkg::ST_DONE;
                end
            end
            lac_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lac_pkg::ST_IDLE;
            end
        endcase
    end

    // step counter for the iterative units
    always_comb
    begin
        step_next = step_reg;
        case (state_reg)
            lac_pkg::ST_DIV_INIT:
            begin
                step_next = lac_pkg::STEP_W'(lac_pkg::DIV_STEPS - 1);
            end
            lac_pkg::ST_FILT_INIT:
            begin
                step_next = lac_pkg::STEP_W'(lac_pkg::FILT_STEPS - 1);
            end
            lac_pkg::ST_FORCE_INIT:
            begin
                step_next = lac_pkg::STEP_W'(lac_pkg::FORCE_STEPS - 1);
            end
            lac_pkg::ST_DIV, lac_pkg::ST_FILT_MUL, lac_pkg::ST_FORCE_MUL:
            begin
                step_next = step_reg - 1'b1;
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    // datapath commands and handshake outputs
    always_comb
    begin
        cmd            = '0;
        in_ready       = (state_reg == lac_pkg::ST_IDLE);
        cmd.capture    = accept;
        cmd.tare_acc   = accept && (phase_reg == lac_pkg::PH_TARE);
        cmd.div_init   = (state_reg == lac_pkg::ST_DIV_INIT);
        cmd.div_step   = (state_reg == lac_pkg::ST_DIV);
        cmd.tare_set   = (state_reg == lac_pkg::ST_TARE_SET);
        cmd.filt_init  = (state_reg == lac_pkg::ST_FILT_INIT);
        cmd.mul_step   = (state_reg == lac_pkg::ST_FILT_MUL) ||
                         (state_reg == lac_pkg::ST_FORCE_MUL);
        cmd.filt_upd   = (state_reg == lac_pkg::ST_FILT_UPD);
        cmd.force_init = (state_reg == lac_pkg::ST_FORCE_INIT);
        cmd.out_load   = (state_reg == lac_pkg::ST_DONE) && out_free;
    end

    // result valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/lac_dp.sv =====
// ----------------------------------------------------------------------------
// lac_dp
// Datapath: configuration registers, tare accumulator with serial divider,
// shared shift-add multiplier for filter and force, angle wrap, result regs.
// ----------------------------------------------------------------------------
module lac_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  lac_pkg::dp_cmd_t                        cmd,
    output lac_pkg::dp_status_t                     status,
    input  logic                                    cfg_we,
    input  logic [lac_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [lac_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [lac_pkg::SAMPLE_W-1:0]     load_raw,
    input  logic [lac_pkg::ANGLE_W-1:0]             angle_raw,
    input  logic                                    angle_ok,
    output logic signed [lac_pkg::FORCE_W-1:0]      force_value,
    output logic signed [lac_pkg::ANGLE_OUT_W-1:0]  angle_counts,
    output logic                                    angle_valid
);

    // configuration
    logic [lac_pkg::ALPHA_W-1:0]        alpha_reg;
    logic [lac_pkg::SCALE_W-1:0]        scale_reg;
    logic [lac_pkg::TARE_N_W-1:0]       tare_n_reg;
    logic                               dir_neg_reg;

    // conditioner state
    logic [lac_pkg::TARE_N_W-1:0]       count_reg;
    logic [lac_pkg::SUM_W-1:0]          sum_reg;
    logic [lac_pkg::TARE_W-1:0]         tare_reg;
    logic [lac_pkg::FILT_W-1:0]         filt_reg;
    logic [lac_pkg::ANGLE_W-1:0]        zero_reg;

    // captured item
    logic [lac_pkg::SAMPLE_W-1:0]       x_reg;
    logic [lac_pkg::ANGLE_W-1:0]        raw_reg;
    logic                               ok_reg;

    // divider and multiplier working registers
    logic [lac_pkg::SUM_W-1:0]          dvd_reg;
    logic [lac_pkg::TARE_N_W-1:0]       rem_reg;
    logic                               sum_neg_reg;
    logic [lac_pkg::PROD_W-1:0]         mcand_reg;
    logic [lac_pkg::SCALE_W-1:0]        mplier_reg;
    logic [lac_pkg::PROD_W-1:0]         acc_reg;
    logic                               neg_reg;

    // result registers
    logic [lac_pkg::FORCE_W-1:0]        force_reg;
    logic [lac_pkg::ANGLE_OUT_W-1:0]    angle_reg;
    logic                               angle_valid_reg;

    logic [lac_pkg::TARE_N_W-1:0]       n_eff;
    logic [lac_pkg::TARE_N_W-1:0]       count_next;
    logic [lac_pkg::SUM_W-1:0]          sum_next;
    logic [lac_pkg::TARE_N_W:0]         rem_shift;
    logic                               q_bit;
    logic [lac_pkg::TARE_N_W-1:0]       rem_next;
    logic [lac_pkg::SUM_W-1:0]          quot_signed;
    logic [lac_pkg::TARE_W-1:0]         tare_next;
    logic [lac_pkg::DIFF_W-1:0]         x_q;
    logic [lac_pkg::DIFF_W-1:0]         filt_ext;
    logic [lac_pkg::DIFF_W-1:0]         tare_q;
    logic [lac_pkg::DIFF_W-1:0]         filt_diff;
    logic [lac_pkg::DIFF_W-1:0]         force_diff;
    logic [lac_pkg::DIFF_W-1:0]         force_mag;
    logic [lac_pkg::SCALE_W-1:0]        scale_mag;
    logic [lac_pkg::FILT_W-1:0]         filt_next;
    logic [lac_pkg::PROD_W-1:0]         acc_next;
    logic [lac_pkg::MAG_W-1:0]          prod_mag;
    logic                               force_sat;
    logic [lac_pkg::FORCE_W-1:0]        force_next;
    logic signed [lac_pkg::ANGLE_DIFF_W-1:0] angle_diff;
    logic signed [lac_pkg::ANGLE_DIFF_W-1:0] angle_wrap;
    logic signed [lac_pkg::ANGLE_DIFF_W-1:0] angle_dir;
    logic [lac_pkg::ANGLE_OUT_W-1:0]    angle_next;

    localparam logic signed [lac_pkg::ANGLE_DIFF_W-1:0] ANGLE_HALF =
        lac_pkg::ANGLE_DIFF_W'(lac_pkg::ANGLE_COUNTS / 2);
    localparam logic signed [lac_pkg::ANGLE_DIFF_W-1:0] ANGLE_FULL =
        lac_pkg::ANGLE_DIFF_W'(lac_pkg::ANGLE_COUNTS);

    // tare count of zero acts as one
    assign n_eff = (tare_n_reg == '0) ? lac_pkg::TARE_N_W'(1) : tare_n_reg;

    // tare accumulation
    assign count_next       = count_reg + 1'b1;
    assign status.tare_last = (count_next >= n_eff);
    assign sum_next         = sum_reg
                            + {{(lac_pkg::SUM_W-lac_pkg::SAMPLE_W){load_raw[lac_pkg::SAMPLE_W-1]}},
                               load_raw};

    // restoring divider step, one quotient bit a cycle
    assign rem_shift = {rem_reg, dvd_reg[lac_pkg::SUM_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, n_eff});
    assign rem_next  = q_bit ? lac_pkg::TARE_N_W'(rem_shift - {1'b0, n_eff})
                             : rem_shift[lac_pkg::TARE_N_W-1:0];

    // quotient back to signed, truncated toward zero
    assign quot_signed = sum_neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    assign tare_next   = quot_signed;

    // filter and force differences in Q.16
    assign x_q        = {{(lac_pkg::DIFF_W-lac_pkg::SAMPLE_W-lac_pkg::FRAC_W)
                           {x_reg[lac_pkg::SAMPLE_W-1]}},
                         x_reg, {lac_pkg::FRAC_W{1'b0}}};
    assign filt_ext   = {filt_reg[lac_pkg::FILT_W-1], filt_reg};
    assign tare_q     = {tare_reg[lac_pkg::TARE_W-1], tare_reg, {lac_pkg::FRAC_W{1'b0}}};
    assign filt_diff  = x_q - filt_ext;
    assign force_diff = filt_ext - tare_q;
    assign force_mag  = force_diff[lac_pkg::DIFF_W-1] ? (~force_diff + 1'b1) : force_diff;
    assign scale_mag  = scale_reg[lac_pkg::SCALE_W-1] ? (~scale_reg + 1'b1) : scale_reg;

    // shift-add multiplier step
    assign acc_next = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

    // filter update: floor of the product by 2^16
    assign filt_next = filt_reg + acc_reg[lac_pkg::FRAC_W +: lac_pkg::FILT_W];

    // force: magnitude shifted down, then signed and saturated
    assign prod_mag   = acc_reg[lac_pkg::PROD_W-1:lac_pkg::FRAC_W];
    assign force_sat  = |prod_mag[lac_pkg::MAG_W-1:lac_pkg::FORCE_W-1];
    always_comb
    begin
        if (force_sat)
        begin
            force_next = neg_reg ? lac_pkg::FORCE_MIN : lac_pkg::FORCE_MAX;
        end
        else if (neg_reg)
        begin
            force_next = ~prod_mag[lac_pkg::FORCE_W-1:0] + 1'b1;
        end
        else
        begin
            force_next = prod_mag[lac_pkg::FORCE_W-1:0];
        end
    end

    // angle tare, wrap to one half turn each side, direction
    assign angle_diff = $signed({2'b00, raw_reg}) - $signed({2'b00, zero_reg});
    always_comb
    begin
        if (angle_diff > ANGLE_HALF)
        begin
            angle_wrap = angle_diff - ANGLE_FULL;
        end
        else if (angle_diff <= -ANGLE_HALF)
        begin
            angle_wrap = angle_diff + ANGLE_FULL;
        end
        else
        begin
            angle_wrap = angle_diff;
        end
    end
    assign angle_dir  = dir_neg_reg ? -angle_wrap : angle_wrap;
    assign angle_next = ok_reg ? angle_dir[lac_pkg::ANGLE_OUT_W-1:0] : '0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= lac_pkg::ALPHA_RST;
            scale_reg   <= lac_pkg::SCALE_RST;
            tare_n_reg  <= lac_pkg::TARE_N_RST;
            dir_neg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lac_pkg::CFG_FILTER_ALPHA:
                begin
                    alpha_reg <= cfg_data[lac_pkg::ALPHA_W-1:0];
                end
                lac_pkg::CFG_FORCE_SCALE:
                begin
                    scale_reg <= cfg_data[lac_pkg::SCALE_W-1:0];
                end
                lac_pkg::CFG_TARE_SAMPLES:
                begin
                    tare_n_reg <= cfg_data[lac_pkg::TARE_N_W-1:0];
                end
                lac_pkg::CFG_DIRECTION_NEGATIVE:
                begin
                    dir_neg_reg <= cfg_data[0];
                end
                default:
                begin
                    dir_neg_reg <= dir_neg_reg;
                end
            endcase
        end
    end

    // conditioner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            tare_reg  <= '0;
            filt_reg  <= '0;
            zero_reg  <= '0;
        end
        else
        begin
            if (cmd.tare_acc)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
            if (cmd.tare_set)
            begin
                tare_reg <= tare_next;
                filt_reg <= {tare_next, {lac_pkg::FRAC_W{1'b0}}};
                if (ok_reg)
                begin
                    zero_reg <= raw_reg;
                end
            end
            else if (cmd.filt_upd)
            begin
                filt_reg <= filt_next;
            end
        end
    end

    // item capture and iterative units
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg   <= load_raw;
            raw_reg <= angle_raw;
            ok_reg  <= angle_ok;
        end
        if (cmd.div_init)
        begin
            dvd_reg     <= sum_reg[lac_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
            rem_reg     <= '0;
            sum_neg_reg <= sum_reg[lac_pkg::SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[lac_pkg::SUM_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
        if (cmd.filt_init)
        begin
            mcand_reg  <= {{(lac_pkg::PROD_W-lac_pkg::DIFF_W){filt_diff[lac_pkg::DIFF_W-1]}},
                           filt_diff};
            mplier_reg <= {{(lac_pkg::SCALE_W-lac_pkg::ALPHA_W){1'b0}}, alpha_reg};
            acc_reg    <= '0;
        end
        else if (cmd.force_init)
        begin
            mcand_reg  <= {{(lac_pkg::PROD_W-lac_pkg::DIFF_W){1'b0}}, force_mag};
            mplier_reg <= scale_mag;
            acc_reg    <= '0;
            neg_reg    <= force_diff[lac_pkg::DIFF_W-1] ^ scale_reg[lac_pkg::SCALE_W-1];
        end
        else if (cmd.mul_step)
        begin
            mcand_reg  <= {mcand_reg[lac_pkg::PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[lac_pkg::SCALE_W-1:1]};
            acc_reg    <= acc_next;
        end
        if (cmd.out_load)
        begin
            force_reg       <= force_next;
            angle_reg       <= angle_next;
            angle_valid_reg <= ok_reg;
        end
    end

    assign force_value  = force_reg;
    assign angle_counts = angle_reg;
    assign angle_valid  = angle_valid_reg;

endmodule

// ===== rtl/core/lac_chk.sv =====
// ----------------------------------------------------------------------------
// lac_chk
// Port-level checks for the conditioner core, bound to the top level.
// ----------------------------------------------------------------------------
module lac_chk (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic signed [lac_pkg::FORCE_W-1:0]      force_value,
    input logic signed [lac_pkg::ANGLE_OUT_W-1:0]  angle_counts,
    input logic                                    angle_valid
);

    // pending result stays up until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(force_value) && $stable(angle_counts) && $stable(angle_valid))
        else $error("result payload changed while stalled");

    // a new result never loads in the cycle a sample is taken
    a_load_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(!out_valid || out_ready) |-> $past(!(in_valid && in_ready)))
        else $error("result loaded in a sample request cycle");

    // failed angle reads report a zero angle
    a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !angle_valid |-> angle_counts == '0)
        else $error("invalid angle with nonzero count");

endmodule

bind load_and_angle_conditioner_core lac_chk u_lac_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample.valid),
    .in_ready     (sample.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .force_value  (result.force_value),
    .angle_counts (result.angle_counts),
    .angle_valid  (result.angle_valid)
);
